// ----- src/cbc_pkg.sv -----
// ----------------------------------------------------------------------------
// cbc_pkg : shared types and constants for the change burst coalescer
// Operation codes, register indexes and the transaction payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

    // operation codes carried by each input transaction
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_GRAPH_ATTACHED = 2'd0;
    localparam logic [1:0] REG_QUIET_MS       = 2'd1;
    localparam logic [1:0] REG_MAX_WAIT_MS    = 2'd2;

    // fixed field geometry
    localparam int EPOCH_W      = 16;
    localparam int EPOCH_FIELDS = 4;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 16;

    // last_reporter code for "no reporter"
    localparam logic [2:0] NO_REPORTER = 3'd4;

    typedef struct packed {
        logic [1:0]          operation;
        logic [TIME_W-1:0]   now_ms;
        logic [EPOCH_W-1:0]  epoch_0;
        logic [EPOCH_W-1:0]  epoch_1;
        logic [EPOCH_W-1:0]  epoch_2;
        logic [EPOCH_W-1:0]  epoch_3;
        logic [EPOCH_FIELDS-1:0] epoch_present;
        logic                retap_fits;
    } t_in_item;

    typedef struct packed {
        logic               acted;
        logic               rebuild_needed;
        logic               burst_open;
        logic [2:0]         last_reporter;
        logic [CNT_W-1:0]   report_count;
        logic [CNT_W-1:0]   burst_count;
        logic [CNT_W-1:0]   forced_count;
        logic [CNT_W-1:0]   retap_count;
        logic [CNT_W-1:0]   rebuild_count;
    } t_out_item;

    // configuration registers as seen by the merge stage
    typedef struct packed {
        logic               graph_attached;
        logic [CFG_W-1:0]   quiet_ms;
        logic [CFG_W-1:0]   max_wait_ms;
    } t_cfg;

    // per-lane control from the top level
    typedef struct packed {
        logic poll;     // accepted poll with graph attached
        logic add;      // accepted add that lands on this slot
        logic clear;    // accepted clear
        logic active;   // slot is registered
    } t_lane_ctl;

endpackage : cbc_pkg

`default_nettype wire

// ----- src/cbc_lane.sv -----
// ----------------------------------------------------------------------------
// cbc_lane : one source slot
// Holds the remembered epoch of its slot and flags a report on a poll
// whenever the current epoch differs from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbc_lane #(
    parameter int EPOCH_BITS = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  cbc_pkg::t_lane_ctl     i_ctl,
    input  wire [EPOCH_BITS-1:0]   i_epoch,
    output logic                   o_report
);

    logic [EPOCH_BITS-1:0] r_seen;
    logic [EPOCH_BITS-1:0] n_seen;

    // report on any difference in a registered slot
    assign o_report = i_ctl.poll && i_ctl.active && (i_epoch != r_seen);

    // remembered epoch update
    always_comb begin
        n_seen = r_seen;
        if (i_ctl.clear) begin
            n_seen = '0;
        end else if (i_ctl.add || o_report) begin
            n_seen = i_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule : cbc_lane

`default_nettype wire

// ----- src/cbc_merge.sv -----
// ----------------------------------------------------------------------------
// cbc_merge : combines lane reports into burst timing and statistics
// Tracks the open burst, decides when to act, keeps the wrapping counters
// and holds the result transaction in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbc_merge #(
    parameter int NUM_SOURCES = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  cbc_pkg::t_in_item       i_item,
    input  cbc_pkg::t_cfg           i_cfg,
    input  wire [NUM_SOURCES-1:0]   i_report,
    input  wire                     i_out_stall,
    output logic                    o_out_valid,
    output cbc_pkg::t_out_item      o_out_data
);

    localparam int RW = $clog2(NUM_SOURCES + 1);

    logic                       r_pending,  n_pending;
    logic [cbc_pkg::TIME_W-1:0] r_first,    n_first;
    logic [cbc_pkg::TIME_W-1:0] r_last,     n_last;
    logic [2:0]                 r_reporter, n_reporter;
    logic                       r_rebuild,  n_rebuild;
    logic [cbc_pkg::CNT_W-1:0]  r_reports,  n_reports;
    logic [cbc_pkg::CNT_W-1:0]  r_bursts,   n_bursts;
    logic [cbc_pkg::CNT_W-1:0]  r_forced,   n_forced;
    logic [cbc_pkg::CNT_W-1:0]  r_retaps,   n_retaps;
    logic [cbc_pkg::CNT_W-1:0]  r_rebuilds, n_rebuilds;
    logic                       r_out_valid;
    cbc_pkg::t_out_item         r_out_data, n_out_data;

    logic                       w_poll;
    logic                       w_clear;
    logic                       w_changed;
    logic [RW-1:0]              w_num_reports;
    logic [2:0]                 w_top_reporter;
    logic                       w_pend_a;
    logic [cbc_pkg::TIME_W-1:0] w_first_a;
    logic [cbc_pkg::TIME_W-1:0] w_last_a;
    logic [cbc_pkg::TIME_W-1:0] w_since_last;
    logic [cbc_pkg::TIME_W-1:0] w_since_first;
    logic                       w_quiet;
    logic                       w_too_long;
    logic                       w_act;

    assign w_poll    = i_accept && (i_item.operation == cbc_pkg::OP_POLL) && i_cfg.graph_attached;
    assign w_clear   = i_accept && (i_item.operation == cbc_pkg::OP_CLEAR);
    assign w_changed = |i_report;

    // merge lane reports: count and highest numbered reporter
    always_comb begin
        w_num_reports  = '0;
        w_top_reporter = cbc_pkg::NO_REPORTER;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            w_num_reports = w_num_reports + RW'(i_report[i]);
            if (i_report[i]) begin
                w_top_reporter = 3'(i);
            end
        end
    end

    // burst timing after this poll's reports
    assign w_pend_a      = r_pending || w_changed;
    assign w_first_a     = (w_changed && !r_pending) ? i_item.now_ms : r_first;
    assign w_last_a      = w_changed ? i_item.now_ms : r_last;
    assign w_since_last  = i_item.now_ms - w_last_a;
    assign w_since_first = i_item.now_ms - w_first_a;
    assign w_quiet       = w_since_last >= cbc_pkg::TIME_W'(i_cfg.quiet_ms);
    assign w_too_long    = (i_cfg.max_wait_ms != '0) &&
                           (w_since_first >= cbc_pkg::TIME_W'(i_cfg.max_wait_ms));
    assign w_act         = w_poll && w_pend_a && (w_quiet || w_too_long);

    // next state
    always_comb begin
        n_pending  = r_pending;
        n_first    = r_first;
        n_last     = r_last;
        n_reporter = r_reporter;
        n_rebuild  = r_rebuild;
        n_reports  = r_reports;
        n_bursts   = r_bursts;
        n_forced   = r_forced;
        n_retaps   = r_retaps;
        n_rebuilds = r_rebuilds;
        if (w_poll) begin
            n_pending = w_pend_a && !w_act;
            n_first   = w_first_a;
            n_last    = w_last_a;
            n_reports = r_reports + cbc_pkg::CNT_W'(w_num_reports);
            if (w_changed) begin
                n_reporter = w_top_reporter;
            end
            if (w_changed && !r_pending) begin
                n_bursts = r_bursts + 1'b1;
            end
            if (w_act) begin
                n_retaps = r_retaps + 1'b1;
                if (!w_quiet) begin
                    n_forced = r_forced + 1'b1;
                end
                if (!i_item.retap_fits) begin
                    n_rebuild  = 1'b1;
                    n_rebuilds = r_rebuilds + 1'b1;
                end
            end
        end else if (w_clear) begin
            n_pending  = 1'b0;
            n_reporter = cbc_pkg::NO_REPORTER;
        end
    end

    // result transaction built from the updated state
    always_comb begin
        n_out_data.acted          = w_act;
        n_out_data.rebuild_needed = n_rebuild;
        n_out_data.burst_open     = n_pending;
        n_out_data.last_reporter  = n_reporter;
        n_out_data.report_count   = n_reports;
        n_out_data.burst_count    = n_bursts;
        n_out_data.forced_count   = n_forced;
        n_out_data.retap_count    = n_retaps;
        n_out_data.rebuild_count  = n_rebuilds;
    end

    // control state and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_first     <= '0;
            r_last      <= '0;
            r_reporter  <= cbc_pkg::NO_REPORTER;
            r_rebuild   <= 1'b0;
            r_reports   <= '0;
            r_bursts    <= '0;
            r_forced    <= '0;
            r_retaps    <= '0;
            r_rebuilds  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_first     <= n_first;
            r_last      <= n_last;
            r_reporter  <= n_reporter;
            r_rebuild   <= n_rebuild;
            r_reports   <= n_reports;
            r_bursts    <= n_bursts;
            r_forced    <= n_forced;
            r_retaps    <= n_retaps;
            r_rebuilds  <= n_rebuilds;
            if (i_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule : cbc_merge

`default_nettype wire

// ----- src/change_burst_coalescer_core.sv -----
// ----------------------------------------------------------------------------
// change_burst_coalescer_core : quiet-period event coalescer with max wait
// Watches up to NUM_SOURCES report epochs in parallel lanes, opens and
// closes bursts of reports, and counts reports, bursts, forced closes, retaps and rebuilds.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------
//   in      | to core   | i_in_valid / o_in_stall   | cbc_pkg::t_in_item
//   out     | from core | o_out_valid / i_out_stall | cbc_pkg::t_out_item
//   cfg     | to core   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One transaction per cycle while o_in_stall is low; its result appears in the cycle after
// acceptance, from the output register. The whole poll (lane compares, merge, 32-bit
// time compares and counter updates) settles in the same cycle as acceptance.
// Synchronous active-low reset clears all state but the output payload register, no clearing pass.
// o_in_stall rises only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module change_burst_coalescer_core #(
    parameter int NUM_SOURCES = 4,
    parameter int EPOCH_BITS  = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  cbc_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output cbc_pkg::t_out_item          o_out_data,
    input  wire                         i_cfg_we,
    input  wire [1:0]                   i_cfg_index,
    input  wire [cbc_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW   = $clog2(NUM_SOURCES + 1);
    localparam int IN_W = (EPOCH_BITS < cbc_pkg::EPOCH_W) ? EPOCH_BITS : cbc_pkg::EPOCH_W;

    logic                       r_graph_attached;
    logic [cbc_pkg::CFG_W-1:0]  r_quiet_ms;
    logic [cbc_pkg::CFG_W-1:0]  r_max_wait_ms;
    logic [AW-1:0]              r_active, n_active;

    logic                       w_accept;
    logic                       w_poll;
    logic                       w_add_ok;
    logic                       w_clear;
    cbc_pkg::t_cfg              w_cfg;
    logic [NUM_SOURCES-1:0]     w_report;
    logic [cbc_pkg::EPOCH_W-1:0] w_ep_raw [cbc_pkg::EPOCH_FIELDS];
    logic [EPOCH_BITS-1:0]      w_lane_ep [NUM_SOURCES];
    cbc_pkg::t_lane_ctl         w_lane_ctl [NUM_SOURCES];

    // input handshake: take a transaction unless a held result is stalled
    assign o_in_stall = o_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_poll   = w_accept && (i_in_data.operation == cbc_pkg::OP_POLL) && r_graph_attached;
    assign w_clear  = w_accept && (i_in_data.operation == cbc_pkg::OP_CLEAR);
    assign w_add_ok = w_accept && (i_in_data.operation == cbc_pkg::OP_ADD) &&
                      (r_active < AW'(NUM_SOURCES));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graph_attached <= 1'b0;
            r_quiet_ms       <= '0;
            r_max_wait_ms    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbc_pkg::REG_GRAPH_ATTACHED: r_graph_attached <= i_cfg_data[0];
                cbc_pkg::REG_QUIET_MS:       r_quiet_ms       <= i_cfg_data;
                cbc_pkg::REG_MAX_WAIT_MS:    r_max_wait_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.graph_attached = r_graph_attached;
    assign w_cfg.quiet_ms       = r_quiet_ms;
    assign w_cfg.max_wait_ms    = r_max_wait_ms;

    // registered source count
    always_comb begin
        n_active = r_active;
        if (w_clear) begin
            n_active = '0;
        end else if (w_add_ok) begin
            n_active = r_active + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            r_active <= n_active;
        end
    end

    assign w_ep_raw[0] = i_in_data.epoch_0;
    assign w_ep_raw[1] = i_in_data.epoch_1;
    assign w_ep_raw[2] = i_in_data.epoch_2;
    assign w_ep_raw[3] = i_in_data.epoch_3;

    // one lane per source slot; slots without an epoch field read zero
    for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_lane
        if (g < cbc_pkg::EPOCH_FIELDS) begin : g_fed
            assign w_lane_ep[g] = i_in_data.epoch_present[g] ?
                                  EPOCH_BITS'(w_ep_raw[g][IN_W-1:0]) : '0;
        end else begin : g_unfed
            assign w_lane_ep[g] = '0;
        end

        assign w_lane_ctl[g].poll   = w_poll;
        assign w_lane_ctl[g].add    = w_add_ok && (r_active == AW'(g));
        assign w_lane_ctl[g].clear  = w_clear;
        assign w_lane_ctl[g].active = AW'(g) < r_active;

        cbc_lane #(
            .EPOCH_BITS (EPOCH_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_lane_ctl[g]),
            .i_epoch  (w_lane_ep[g]),
            .o_report (w_report[g])
        );
    end

    // merge stage and output register
    cbc_merge #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_data),
        .i_cfg       (w_cfg),
        .i_report    (w_report),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule : change_burst_coalescer_core

`default_nettype wire

// ----- src/cbc_checker.sv -----
// ----------------------------------------------------------------------------
// cbc_checker : port-level checks for the change burst coalescer
// Watches the handshakes and result transactions at the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbc_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input cbc_pkg::t_out_item   o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // every accepted transaction yields a result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // acting closes the burst
    a_act_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.acted) |-> !o_out_data.burst_open)
        else $error("burst still open after acting");

endmodule : cbc_checker

bind change_burst_coalescer_core cbc_checker u_cbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for change_burst_coalescer_core
// A short directed table (detached polls, capacity, time wrap, quiet and
// forced closes, clears, register extremes) is followed by phases of random
// add/poll/clear traffic under changing register settings. Both channels
// idle and stall in random bursts. Every result transaction is compared
// field by field with an in-bench model of the coalescer, or with a fixed idle result for marked rows.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 250;
    localparam int TAIL_START     = 1800;

    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result of any item that leaves the block in its reset state
    localparam cbc_pkg::t_out_item IDLE_RESULT =
        cbc_pkg::t_out_item'({3'b000, cbc_pkg::NO_REPORTER, {5 * cbc_pkg::CNT_W{1'b0}}});

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    cbc_pkg::t_in_item         i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    cbc_pkg::t_out_item        o_out_data;
    logic                      i_cfg_we    = 1'b0;
    logic [1:0]                i_cfg_index = cbc_pkg::REG_GRAPH_ATTACHED;
    logic [cbc_pkg::CFG_W-1:0] i_cfg_data  = '0;

    change_burst_coalescer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // coalescer model state and registers
    // ------------------------------------------------------------------
    logic [cbc_pkg::EPOCH_W-1:0] slot_seen [cbc_pkg::EPOCH_FIELDS];
    int unsigned                 slot_count;
    logic                        burst_pending;
    logic [cbc_pkg::TIME_W-1:0]  burst_first_ms;
    logic [cbc_pkg::TIME_W-1:0]  burst_last_ms;
    logic [2:0]                  last_slot;
    logic                        rebuild_sticky;
    logic [cbc_pkg::CNT_W-1:0]   n_reports, n_bursts, n_forced, n_retaps, n_rebuilds;
    logic                        cfg_graph;
    logic [cbc_pkg::CFG_W-1:0]   cfg_quiet;
    logic [cbc_pkg::CFG_W-1:0]   cfg_max_wait;

    // epoch of one slot as seen by the block: zero unless present
    function automatic logic [cbc_pkg::EPOCH_W-1:0] slot_epoch(cbc_pkg::t_in_item it,
                                                               int slot);
        logic [cbc_pkg::EPOCH_W-1:0] e;
        if (!it.epoch_present[slot])
            return '0;
        case (slot)
            0:       e = it.epoch_0;
            1:       e = it.epoch_1;
            2:       e = it.epoch_2;
            default: e = it.epoch_3;
        endcase
        return e;
    endfunction

    // advance the model by one input transaction, return its result
    function automatic cbc_pkg::t_out_item coalesce_step(cbc_pkg::t_in_item it);
        cbc_pkg::t_out_item          r;
        logic                        changed;
        logic                        quiet;
        logic                        too_long;
        logic [cbc_pkg::EPOCH_W-1:0] e;
        logic [cbc_pkg::TIME_W-1:0]  since_last;
        logic [cbc_pkg::TIME_W-1:0]  since_first;
        r = '0;
        case (it.operation)
            cbc_pkg::OP_POLL: if (cfg_graph) begin
                changed = 1'b0;
                for (int i = 0; i < cbc_pkg::EPOCH_FIELDS; i++) begin
                    if (i < slot_count) begin
                        e = slot_epoch(it, i);
                        if (e != slot_seen[i]) begin
                            slot_seen[i] = e;
                            changed      = 1'b1;
                            n_reports++;
                            last_slot    = 3'(i);
                        end
                    end
                end
                if (changed) begin
                    if (!burst_pending) begin
                        burst_pending  = 1'b1;
                        burst_first_ms = it.now_ms;
                        n_bursts++;
                    end
                    burst_last_ms = it.now_ms;
                end
                // close on quiet period or on the maximum wait, both mod 2^32
                if (burst_pending) begin
                    since_last  = it.now_ms - burst_last_ms;
                    since_first = it.now_ms - burst_first_ms;
                    quiet    = since_last >= cbc_pkg::TIME_W'(cfg_quiet);
                    too_long = (cfg_max_wait != '0) &&
                               (since_first >= cbc_pkg::TIME_W'(cfg_max_wait));
                    if (quiet || too_long) begin
                        if (!quiet)
                            n_forced++;
                        burst_pending = 1'b0;
                        n_retaps++;
                        if (!it.retap_fits) begin
                            rebuild_sticky = 1'b1;
                            n_rebuilds++;
                        end
                        r.acted = 1'b1;
                    end
                end
            end
            cbc_pkg::OP_ADD: if (slot_count < cbc_pkg::EPOCH_FIELDS) begin
                slot_seen[slot_count] = slot_epoch(it, slot_count);
                slot_count++;
            end
            cbc_pkg::OP_CLEAR: begin
                foreach (slot_seen[i])
                    slot_seen[i] = '0;
                slot_count    = 0;
                burst_pending = 1'b0;
                last_slot     = cbc_pkg::NO_REPORTER;
            end
            default: ;
        endcase
        r.rebuild_needed = rebuild_sticky;
        r.burst_open     = burst_pending;
        r.last_reporter  = last_slot;
        r.report_count   = n_reports;
        r.burst_count    = n_bursts;
        r.forced_count   = n_forced;
        r.retap_count    = n_retaps;
        r.rebuild_count  = n_rebuilds;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    typedef struct {
        logic               fixed;
        cbc_pkg::t_out_item res;
    } t_fixed_row;

    cbc_pkg::t_out_item expected_results [$];
    t_fixed_row         fixed_results [$];
    int                 fail_count = 0;
    logic               tail_phase = 1'b0;

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // compare leaving transactions, then queue the prediction of any accepted one
    always @(posedge i_clk) begin : result_check
        cbc_pkg::t_out_item want;
        t_fixed_row         fx;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, o_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("acted",          want.acted,          o_out_data.acted);
                    check_field("rebuild_needed", want.rebuild_needed, o_out_data.rebuild_needed);
                    check_field("burst_open",     want.burst_open,     o_out_data.burst_open);
                    check_field("last_reporter",  want.last_reporter,  o_out_data.last_reporter);
                    check_field("report_count",   want.report_count,   o_out_data.report_count);
                    check_field("burst_count",    want.burst_count,    o_out_data.burst_count);
                    check_field("forced_count",   want.forced_count,   o_out_data.forced_count);
                    check_field("retap_count",    want.retap_count,    o_out_data.retap_count);
                    check_field("rebuild_count",  want.rebuild_count,  o_out_data.rebuild_count);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = coalesce_step(i_in_data);
                fx   = fixed_results.pop_front();
                expected_results = {expected_results, fx.fixed ? fx.res : want};
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output stall: random bursts, calm stretches, none in the tail
    initial begin : out_stall_gen
        int   burst_left;
        int   calm_left;
        logic calm;
        burst_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 200);
            end else begin
                calm_left--;
            end
            if (tail_phase) begin
                burst_left  = 0;
                i_out_stall <= 1'b0;
            end else if (burst_left != 0) begin
                i_out_stall <= 1'b1;
                burst_left--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                burst_left  = $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    typedef struct {
        logic                      is_cfg;
        logic                      graph;
        logic [cbc_pkg::CFG_W-1:0] quiet;
        logic [cbc_pkg::CFG_W-1:0] max_wait;
        cbc_pkg::t_in_item         item;
        logic                      fixed;
    } t_stim_row;

    t_stim_row stim_table [$];
    logic      send_calm      = 1'b0;
    int        send_calm_left = 0;

    function automatic cbc_pkg::t_in_item mk_item(
            logic [1:0] op, logic [cbc_pkg::TIME_W-1:0] now,
            logic [cbc_pkg::EPOCH_W-1:0] e0, logic [cbc_pkg::EPOCH_W-1:0] e1,
            logic [cbc_pkg::EPOCH_W-1:0] e2, logic [cbc_pkg::EPOCH_W-1:0] e3,
            logic [cbc_pkg::EPOCH_FIELDS-1:0] pres, logic fits);
        cbc_pkg::t_in_item it;
        it.operation     = op;
        it.now_ms        = now;
        it.epoch_0       = e0;
        it.epoch_1       = e1;
        it.epoch_2       = e2;
        it.epoch_3       = e3;
        it.epoch_present = pres;
        it.retap_fits    = fits;
        return it;
    endfunction

    task automatic tab_item(
            logic [1:0] op, logic [cbc_pkg::TIME_W-1:0] now,
            logic [cbc_pkg::EPOCH_W-1:0] e0, logic [cbc_pkg::EPOCH_W-1:0] e1,
            logic [cbc_pkg::EPOCH_W-1:0] e2, logic [cbc_pkg::EPOCH_W-1:0] e3,
            logic [cbc_pkg::EPOCH_FIELDS-1:0] pres, logic fits, logic fixed);
        t_stim_row row;
        row        = '{default: '0};
        row.item   = mk_item(op, now, e0, e1, e2, e3, pres, fits);
        row.fixed  = fixed;
        stim_table = {stim_table, row};
    endtask

    task automatic tab_cfg(logic graph, logic [cbc_pkg::CFG_W-1:0] quiet,
                           logic [cbc_pkg::CFG_W-1:0] max_wait);
        t_stim_row row;
        row          = '{default: '0};
        row.is_cfg   = 1'b1;
        row.graph    = graph;
        row.quiet    = quiet;
        row.max_wait = max_wait;
        stim_table   = {stim_table, row};
    endtask

    // one input transaction, with an optional random idle gap in front
    task automatic send_item(cbc_pkg::t_in_item it, logic fixed,
                             cbc_pkg::t_out_item fixed_res);
        int         gap;
        t_fixed_row fx;
        gap = 0;
        if (send_calm_left == 0) begin
            send_calm      = ($urandom_range(0, 3) == 0);
            send_calm_left = $urandom_range(30, 150);
        end else begin
            send_calm_left--;
        end
        if (!tail_phase && !send_calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        fx.fixed = fixed;
        fx.res   = fixed_res;
        fixed_results = {fixed_results, fx};
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // drain every outstanding result, then write all three registers
    task automatic set_config(logic graph, logic [cbc_pkg::CFG_W-1:0] quiet,
                              logic [cbc_pkg::CFG_W-1:0] max_wait);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cbc_pkg::REG_GRAPH_ATTACHED;
        i_cfg_data  <= cbc_pkg::CFG_W'(graph);
        @(posedge i_clk);
        cfg_graph   = graph;
        i_cfg_index <= cbc_pkg::REG_QUIET_MS;
        i_cfg_data  <= quiet;
        @(posedge i_clk);
        cfg_quiet   = quiet;
        i_cfg_index <= cbc_pkg::REG_MAX_WAIT_MS;
        i_cfg_data  <= max_wait;
        @(posedge i_clk);
        cfg_max_wait = max_wait;
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [cbc_pkg::EPOCH_W-1:0]      stim_epoch [cbc_pkg::EPOCH_FIELDS];
        logic [cbc_pkg::CFG_W-1:0]        q_ms;
        logic [cbc_pkg::CFG_W-1:0]        w_ms;
        logic [cbc_pkg::TIME_W-1:0]       clock_ms;
        logic [cbc_pkg::EPOCH_FIELDS-1:0] pres;
        int unsigned                      step_span;
        int                               sel;
        cbc_pkg::t_in_item                it;

        // model in its reset state
        foreach (slot_seen[i])
            slot_seen[i] = '0;
        slot_count     = 0;
        burst_pending  = 1'b0;
        burst_first_ms = '0;
        burst_last_ms  = '0;
        last_slot      = cbc_pkg::NO_REPORTER;
        rebuild_sticky = 1'b0;
        n_reports      = '0;
        n_bursts       = '0;
        n_forced       = '0;
        n_retaps       = '0;
        n_rebuilds     = '0;
        cfg_graph      = 1'b0;
        cfg_quiet      = '0;
        cfg_max_wait   = '0;

        // directed table
        // detached poll and unused opcode leave the reset state untouched
        tab_item(cbc_pkg::OP_POLL,  32'hFFFF_FFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b0, 1'b1);
        tab_item(OP_UNUSED,         32'h0000_0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b1);
        // adds work without a graph; an absent epoch seeds as zero
        tab_item(cbc_pkg::OP_ADD,   32'h0000_0000,
                 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'hF, 1'b1, 1'b0);
        tab_cfg(1'b1, 16'd10, 16'd25);
        tab_item(cbc_pkg::OP_ADD,   32'h0000_0001,
                 16'hFFFF, 16'h1234, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_ADD,   32'h0000_0002,
                 16'hFFFF, 16'h0001, 16'hAAAA, 16'h0000, 4'hF, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_ADD,   32'h0000_0003,
                 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555, 4'hF, 1'b1, 1'b0);
        // beyond capacity
        tab_item(cbc_pkg::OP_ADD,   32'h0000_0004,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b0, 1'b0);
        // two reporters in one poll, burst opens just before the time wrap
        tab_item(cbc_pkg::OP_POLL,  32'hFFFF_FFF0,
                 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5556, 4'hF, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'hFFFF_FFF8,
                 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5556, 4'hE, 1'b1, 1'b0);
        // quiet close across the wrap, retap does not fit
        tab_item(cbc_pkg::OP_POLL,  32'h0000_0004,
                 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5556, 4'hE, 1'b0, 1'b0);
        // steady reports until the maximum wait forces a close
        tab_item(cbc_pkg::OP_POLL,  32'h0000_0005,
                 16'hFFFF, 16'h0001, 16'hAAAB, 16'h5556, 4'hE, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_000A,
                 16'hFFFF, 16'h0001, 16'hAAAC, 16'h5556, 4'hE, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_0012,
                 16'hFFFF, 16'h0001, 16'hAAAD, 16'h5556, 4'hE, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_001A,
                 16'hFFFF, 16'h0001, 16'hAAAE, 16'h5556, 4'hE, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_001E,
                 16'hFFFF, 16'h0001, 16'hAAAF, 16'h5556, 4'hE, 1'b1, 1'b0);
        // zero quiet time: every report closes at once
        tab_cfg(1'b1, 16'd0, 16'd0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_0064,
                 16'hFFFF, 16'h0001, 16'h0000, 16'h5556, 4'hE, 1'b0, 1'b0);
        // clear keeps the sticky flag and the statistics
        tab_item(cbc_pkg::OP_CLEAR, 32'h0000_0065,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_0066,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 1'b0);
        // largest settings, close exactly at the limit
        tab_cfg(1'b1, 16'hFFFF, 16'hFFFF);
        tab_item(cbc_pkg::OP_ADD,   32'h0000_0067,
                 16'h0007, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0000_1000,
                 16'h0008, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0001_0FFE,
                 16'h0008, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b1, 1'b0);
        tab_item(cbc_pkg::OP_POLL,  32'h0001_0FFF,
                 16'h0008, 16'h0000, 16'h0000, 16'h0000, 4'h1, 1'b1, 1'b0);

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (stim_table[r]) begin
            if (stim_table[r].is_cfg)
                set_config(stim_table[r].graph, stim_table[r].quiet, stim_table[r].max_wait);
            else
                send_item(stim_table[r].item, stim_table[r].fixed, IDLE_RESULT);
        end

        // random phases, each under its own register setting
        foreach (stim_epoch[i])
            stim_epoch[i] = cbc_pkg::EPOCH_W'($urandom);
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    q_ms = '0;
                    w_ms = '0;
                end
                1: begin
                    q_ms = '1;
                    w_ms = '1;
                end
                2: begin
                    q_ms = '1;
                    w_ms = '0;
                end
                3: begin
                    q_ms = '0;
                    w_ms = '1;
                end
                default: begin
                    q_ms = ($urandom_range(0, 1) != 0) ?
                           cbc_pkg::CFG_W'($urandom_range(0, 300)) : cbc_pkg::CFG_W'($urandom);
                    w_ms = ($urandom_range(0, 1) != 0) ?
                           cbc_pkg::CFG_W'($urandom_range(0, 300)) : cbc_pkg::CFG_W'($urandom);
                end
            endcase
            set_config(ph != 5, q_ms, w_ms);
            clock_ms  = $urandom;
            step_span = ((q_ms > w_ms) ? q_ms : w_ms) / 4 + 4;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph * PHASE_ITEMS + k >= TAIL_START)
                    tail_phase = 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 6) begin
                    // noise, any opcode and any field value
                    it = mk_item(2'($urandom_range(0, 3)), $urandom,
                                 cbc_pkg::EPOCH_W'($urandom), cbc_pkg::EPOCH_W'($urandom),
                                 cbc_pkg::EPOCH_W'($urandom), cbc_pkg::EPOCH_W'($urandom),
                                 cbc_pkg::EPOCH_FIELDS'($urandom), 1'($urandom));
                end else if (sel < 9 || k == 0) begin
                    it = mk_item(cbc_pkg::OP_CLEAR, $urandom,
                                 cbc_pkg::EPOCH_W'($urandom), cbc_pkg::EPOCH_W'($urandom),
                                 cbc_pkg::EPOCH_W'($urandom), cbc_pkg::EPOCH_W'($urandom),
                                 cbc_pkg::EPOCH_FIELDS'($urandom), 1'($urandom));
                end else if (sel < 17 || k < 3) begin
                    pres = ($urandom_range(0, 7) == 0) ? cbc_pkg::EPOCH_FIELDS'($urandom) : '1;
                    it = mk_item(cbc_pkg::OP_ADD, $urandom, stim_epoch[0], stim_epoch[1],
                                 stim_epoch[2], stim_epoch[3], pres, 1'($urandom));
                end else begin
                    // poll: time moves on, some sources report
                    if ($urandom_range(0, 49) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms = clock_ms + $urandom_range(0, step_span);
                    foreach (stim_epoch[i])
                        if ($urandom_range(0, 5) == 0)
                            stim_epoch[i] = cbc_pkg::EPOCH_W'($urandom);
                    pres = ($urandom_range(0, 9) == 0) ? cbc_pkg::EPOCH_FIELDS'($urandom) : '1;
                    it = mk_item(cbc_pkg::OP_POLL, clock_ms, stim_epoch[0], stim_epoch[1],
                                 stim_epoch[2], stim_epoch[3], pres, 1'($urandom));
                end
                send_item(it, 1'b0, IDLE_RESULT);
            end
        end

        // drain and finish
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
